[design/itad_pkg.sv]
// Package: shared constants, state encoding and cell control struct.
`default_nettype none
package itad_pkg;

  localparam int NumCells   = 10;
  localparam int BinDigits  = 8;
  localparam int ConvCycles = 32;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharMinus = 8'h2D;

  localparam logic [1:0] ModeSigned = 2'd0;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SIGN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  typedef struct packed {
    logic load;
    logic conv;
    logic move;
  } cell_ctl_t;

endpackage
`default_nettype wire

[design/itad_cell.sv]
// One BCD digit cell: double-dabble shift step, parallel load, digit shift.
`default_nettype none
module itad_cell (
  input  wire logic              clk,
  input  wire itad_pkg::cell_ctl_t ctl,
  input  wire logic [3:0]        load_digit,
  input  wire logic              carry_in,
  input  wire logic [3:0]        digit_in,
  output logic      [3:0]        digit,
  output logic                   carry_out
);

  logic [3:0] corr;

  always_comb begin
    corr = (digit >= 4'd5) ? digit + 4'd3 : digit;
  end

  assign carry_out = corr[3];

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      digit <= load_digit;
    end else if (ctl.conv) begin
      digit <= {corr[2:0], carry_in};
    end else if (ctl.move) begin
      digit <= digit_in;
    end
  end

endmodule
`default_nettype wire

[design/integer_to_ascii_digits.sv]
// Top level: 32-bit word to ASCII decimal or binary character stream.
// Usage:
//   Input request (s_tvalid/s_tready/s_tdata) carries value[31:0] and
//   mode[33:32]. Mode 0 prints signed decimal with a leading '-', mode 1
//   unsigned decimal, modes 2 and 3 the eight bits of the low byte.
//   Output requests (m_tvalid/m_tready/m_tdata/m_tlast) carry one ASCII
//   character each, most significant first; m_tlast marks the final one.
// Steps:
//   Decimal: a load, double-dabble shifts through a chain of ten BCD cells,
//   a '-' when negative, then the ten digits leave the top of the chain in
//   turn, leading zeros dropped and one character sent for each of the rest.
//   Binary: a load then 8 characters, one per cycle unless m_tready stalls.
//   One word is handled at a time; s_tready is high only when idle. The
//   final character may still sit in the output register when the next
//   word is accepted.
// Reset: rst (synchronous, active high) returns to idle and drops m_tvalid.
// Stall: a low m_tready holds the output register, and the next character
//   waits at the top of the digit chain until the pending one is taken;
//   leading zeros are still dropped meanwhile.
`default_nettype none
module integer_to_ascii_digits (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // value[31:0], mode[33:32], zero pad
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [7:0]  m_tdata,   // character[7:0]
  output logic             m_tlast
);

  localparam int CntW = $clog2(itad_pkg::ConvCycles);
  localparam int RemW = $clog2(itad_pkg::NumCells + 1);

  itad_pkg::state_t state, state_next;
  itad_pkg::cell_ctl_t ctl;

  logic [31:0]     mag;
  logic [CntW-1:0] cnt;
  logic [RemW-1:0] remaining;
  logic            started;
  logic            negative;

  logic [3:0] digit [itad_pkg::NumCells];
  logic       carry [itad_pkg::NumCells];
  logic [3:0] top;

  logic [31:0] in_value;
  logic [1:0]  in_mode;
  logic        in_fire;
  logic        in_neg;
  logic        out_free;
  logic        skip;
  logic        send_digit;
  logic        send_sign;

  assign in_value = s_tdata[31:0];
  assign in_mode  = s_tdata[33:32];
  assign in_neg   = (in_mode == itad_pkg::ModeSigned) && in_value[31];

  assign s_tready = (state == itad_pkg::ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign top      = digit[itad_pkg::NumCells-1];

  assign skip       = (state == itad_pkg::ST_EMIT) && !started && (top == 4'd0)
                      && (remaining != RemW'(1));
  assign send_digit = (state == itad_pkg::ST_EMIT) && !skip && out_free;
  assign send_sign  = (state == itad_pkg::ST_SIGN) && out_free;

  assign ctl.load = in_fire;
  assign ctl.conv = (state == itad_pkg::ST_CONV);
  assign ctl.move = skip || send_digit;

  for (genvar i = 0; i < itad_pkg::NumCells; i++) begin : g_cell
    logic [3:0] ld;
    logic       cin;
    logic [3:0] din;
    if (i >= itad_pkg::NumCells - itad_pkg::BinDigits) begin : g_bin
      assign ld = {3'b000,
                   in_value[i - (itad_pkg::NumCells - itad_pkg::BinDigits)] & in_mode[1]};
    end else begin : g_zero
      assign ld = 4'd0;
    end
    if (i == 0) begin : g_first
      assign cin = mag[31];
      assign din = 4'd0;
    end else begin : g_next
      assign cin = carry[i-1];
      assign din = digit[i-1];
    end
    itad_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .load_digit (ld),
      .carry_in   (cin),
      .digit_in   (din),
      .digit      (digit[i]),
      .carry_out  (carry[i])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      itad_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_next = in_mode[1] ? itad_pkg::ST_EMIT : itad_pkg::ST_CONV;
        end
      end
      itad_pkg::ST_CONV: begin
        if (cnt == CntW'(itad_pkg::ConvCycles - 1)) begin
          state_next = negative ? itad_pkg::ST_SIGN : itad_pkg::ST_EMIT;
        end
      end
      itad_pkg::ST_SIGN: begin
        if (send_sign) begin
          state_next = itad_pkg::ST_EMIT;
        end
      end
      itad_pkg::ST_EMIT: begin
        if (send_digit && (remaining == RemW'(1))) begin
          state_next = itad_pkg::ST_IDLE;
        end
      end
      default: state_next = itad_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= itad_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (send_digit || send_sign) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mag       <= in_neg ? 32'd0 - in_value : in_value;
      negative  <= in_neg;
      cnt       <= '0;
      started   <= in_mode[1];
      remaining <= in_mode[1] ? RemW'(itad_pkg::BinDigits) : RemW'(itad_pkg::NumCells);
    end else begin
      if (ctl.conv) begin
        mag <= {mag[30:0], 1'b0};
        cnt <= cnt + CntW'(1);
      end
      if (ctl.move) begin
        remaining <= remaining - RemW'(1);
      end
      if (send_digit) begin
        started <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (send_sign) begin
      m_tdata <= itad_pkg::CharMinus;
      m_tlast <= 1'b0;
    end else if (send_digit) begin
      m_tdata <= itad_pkg::CharZero + {4'd0, top};
      m_tlast <= (remaining == RemW'(1));
    end
  end

endmodule
`default_nettype wire

[design/itad_checker.sv]
// Port-level checker for the ASCII digit converter, bound to the top level.
`default_nettype none
module itad_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [39:0] s_tdata,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [7:0]  m_tdata,
  input wire logic        m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output request changed while stalled");

  a_one_word: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second word accepted while converting");

  a_char_set: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata >= 8'h30) && (m_tdata <= 8'h39)) || (m_tdata == 8'h2D))
    else $error("character outside digit and minus set");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata == 8'h2D) |-> !m_tlast)
    else $error("minus sign ended a number");

  a_idle_pending_last: assert property (@(posedge clk) disable iff (rst)
    s_tready && m_tvalid |-> m_tlast)
    else $error("idle with an unfinished number pending");

endmodule

bind integer_to_ascii_digits itad_checker u_itad_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
`default_nettype wire

[tb/testbench.sv]
// Testbench for integer_to_ascii_digits: directed and random words checked character by character.
module testbench;

  localparam logic [1:0] ModeUnsigned  = 2'd1;
  localparam logic [1:0] ModeBinary    = 2'd2;
  localparam logic [1:0] ModeBinaryAlt = 2'd3;
  localparam int unsigned DecBase      = 10;
  localparam int WatchdogLimit = 3000;
  localparam int MaxReports    = 10;
  localparam int SettleCycles  = 60;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  char_item_t expected_chars[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_len = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int mismatches = 0;
  int unexpected = 0;
  int chars_checked = 0;
  int words_sent = 0;
  int mode_count[4] = '{0, 0, 0, 0};
  int quiet_cycles = 0;

  integer_to_ascii_digits u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Expected text of one word, most significant character first.
  function automatic void queue_text(logic [31:0] word, logic [1:0] mode);
    logic [31:0] mag;
    logic [7:0]  digits[10];
    int n;
    int i;
    if (mode == ModeBinary || mode == ModeBinaryAlt) begin
      for (i = 7; i >= 0; i--)
        expected_chars.push_back('{itad_pkg::CharZero + {7'd0, word[i]}, i == 0});
    end else begin
      mag = word;
      if (mode == itad_pkg::ModeSigned && word[31]) begin
        expected_chars.push_back('{itad_pkg::CharMinus, 1'b0});
        mag = 32'd0 - word;
      end
      n = 0;
      do begin
        digits[n] = itad_pkg::CharZero + 8'(mag % DecBase);
        mag = mag / DecBase;
        n++;
      end while (mag != 0);
      for (i = n - 1; i >= 0; i--)
        expected_chars.push_back('{digits[i], i == 0});
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      queue_text(s_tdata[31:0], s_tdata[33:32]);
      mode_count[s_tdata[33:32]]++;
      words_sent++;
    end
  end

  always @(posedge clk) begin
    char_item_t exp_item;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_chars.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= MaxReports)
          $display("unexpected character %h last %b", m_tdata, m_tlast);
      end else begin
        exp_item = expected_chars.pop_front();
        chars_checked++;
        if (m_tdata !== exp_item.ch || m_tlast !== exp_item.last) begin
          mismatches++;
          if (mismatches + unexpected <= MaxReports)
            $display("mismatch: expected char %h last %b, got char %h last %b",
                     exp_item.ch, exp_item.last, m_tdata, m_tlast);
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when requested.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("timeout with %0d characters outstanding", expected_chars.size());
        $display("testbench failed");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [31:0] word, input logic [1:0] mode);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, mode, word};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic test_directed();
    send_word(32'd0, itad_pkg::ModeSigned);
    send_word(32'd0, ModeUnsigned);
    send_word(32'd1, itad_pkg::ModeSigned);
    send_word(32'hFFFF_FFFF, itad_pkg::ModeSigned);
    send_word(32'hFFFF_FFFF, ModeUnsigned);
    send_word(32'h8000_0000, itad_pkg::ModeSigned);
    send_word(32'h8000_0000, ModeUnsigned);
    send_word(32'h7FFF_FFFF, itad_pkg::ModeSigned);
    send_word(32'd9, ModeUnsigned);
    send_word(32'd10, itad_pkg::ModeSigned);
    send_word(32'd100, ModeUnsigned);
    send_word(32'd999_999_999, itad_pkg::ModeSigned);
    send_word(32'd1_000_000_000, ModeUnsigned);
    send_word(32'hFFFF_FFF6, itad_pkg::ModeSigned);
    send_word(32'd4_000_000_000, ModeUnsigned);
    send_word(32'h0000_0000, ModeBinary);
    send_word(32'h0000_00FF, ModeBinary);
    send_word(32'hDEAD_BEA5, ModeBinary);
    send_word(32'h1234_565A, ModeBinaryAlt);
    send_word(32'hFFFF_FF00, ModeBinaryAlt);
  endtask

  task automatic test_random(input int count);
    logic [31:0] word;
    logic [1:0]  mode;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0: word = $urandom;
        1: word = $urandom >> $urandom_range(0, 31);
        2: word = $urandom_range(0, 20);
        default: word = 32'd0 - $urandom_range(1, 100000);
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3: mode = itad_pkg::ModeSigned;
        4, 5, 6:    mode = ModeUnsigned;
        7, 8:       mode = ModeBinary;
        default:    mode = ModeBinaryAlt;
      endcase
      send_word(word, mode);
    end
  endtask

  // Output held off while words keep coming: the block must stall its input.
  task automatic test_backpressure();
    hold_len = 400;
    hold_req++;
    test_random(12);
  endtask

  // Sender stops until every character is out, then resumes.
  task automatic test_drain_pause();
    test_random(6);
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (expected_chars.size() == 0);
    repeat (SettleCycles) @(posedge clk);
    test_random(6);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 38;
    recv_idle_pct = 69;
    test_directed();
    test_random(80);
    send_idle_pct = 69;
    recv_idle_pct = 38;
    test_random(80);
    test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(70);
    test_drain_pause();
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (expected_chars.size() == 0);
    repeat (SettleCycles) @(posedge clk);
    $display("%0d words sent: %0d signed, %0d unsigned, %0d binary (mode 2/3: %0d/%0d)",
             words_sent, mode_count[0], mode_count[1], mode_count[2] + mode_count[3],
             mode_count[2], mode_count[3]);
    $display("%0d characters checked, %0d mismatches, %0d unexpected, %0d missing",
             chars_checked, mismatches, unexpected, expected_chars.size());
    if (mismatches == 0 && unexpected == 0 && expected_chars.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

[filelist.f]
design/itad_pkg.sv
design/itad_cell.sv
design/integer_to_ascii_digits.sv
design/itad_checker.sv
tb/testbench.sv
